// File: hdl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared constants for the clarke/park transform unit
// Sample width default, mode codes and the Q1.30 projection constants.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // default sample width (signed, one integer bit)
  localparam int CPT_SAMPLE_WIDTH = 16;

  // mode codes
  localparam logic CPT_MODE_FWD = 1'b0;
  localparam logic CPT_MODE_INV = 1'b1;

  // Q1.30 constants and their width
  localparam int CPT_K_W    = 31;
  localparam int CPT_K_FRAC = 30;
  localparam logic signed [CPT_K_W-1:0] CPT_K_THIRD      = 31'sd357913941;
  localparam logic signed [CPT_K_W-1:0] CPT_K_INV_SQRT3  = 31'sd619925131;
  localparam logic signed [CPT_K_W-1:0] CPT_K_HALF_SQRT3 = 31'sd929887697;

endpackage

// File: hdl/cpt_clarke.sv
// ----------------------------------------------------------------------------
// cpt_clarke: clarke projection front end
// Three stages: phase pre-add, constant multiply, round to alpha/beta.
// In inverse mode d and q pass through as the rotation operands.
// ----------------------------------------------------------------------------
module cpt_clarke
  import cpt_pkg::*;
#(
  parameter int W = CPT_SAMPLE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic signed [W-1:0] x1,
  input  logic signed [W-1:0] x2,
  input  logic signed [W-1:0] x3,
  input  logic signed [W-1:0] sn,
  input  logic signed [W-1:0] cs,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_mode,
  output logic signed [W:0]   op_x,
  output logic signed [W:0]   op_y,
  output logic signed [W-1:0] out_sn,
  output logic signed [W-1:0] out_cs
);

  localparam int SUM_W = W + 2;
  localparam int DIF_W = W + 1;
  localparam int PA_W  = SUM_W + CPT_K_W;
  localparam int PB_W  = DIF_W + CPT_K_W;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic                    mode1_r, mode2_r, mode3_r;
  logic signed [SUM_W-1:0] sum1_r, sum1_nxt;
  logic signed [DIF_W-1:0] dif1_r, dif1_nxt;
  logic signed [W-1:0]     x1_1_r, x2_1_r, sn1_r, cs1_r;
  logic signed [PA_W-1:0]  pa2_r, pa2_nxt, rnd_a;
  logic signed [PB_W-1:0]  pb2_r, pb2_nxt, rnd_b;
  logic signed [W-1:0]     x1_2_r, x2_2_r, sn2_r, cs2_r;
  logic signed [W:0]       opx3_r, opx3_nxt, opy3_r, opy3_nxt;
  logic signed [W-1:0]     sn3_r, cs3_r;

  // elastic stage enables, a stage moves when empty or when its successor moves
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: pre-add of the phases
  assign sum1_nxt = SUM_W'(x1) - (SUM_W'(x2) <<< 1) + SUM_W'(x3);
  assign dif1_nxt = DIF_W'(x1) - DIF_W'(x3);

  // stage 2: multiply by 1/3 and 1/sqrt(3)
  assign pa2_nxt = PA_W'(sum1_r) * PA_W'(CPT_K_THIRD);
  assign pb2_nxt = PB_W'(dif1_r) * PB_W'(CPT_K_INV_SQRT3);

  // stage 3: round to alpha/beta, or pass d/q through
  assign rnd_a = pa2_r + (PA_W'(1) <<< (CPT_K_FRAC - 1));
  assign rnd_b = pb2_r + (PB_W'(1) <<< (CPT_K_FRAC - 1));

  always_comb begin
    if (mode2_r == CPT_MODE_INV) begin
      opx3_nxt = (W+1)'(x1_2_r);
      opy3_nxt = (W+1)'(x2_2_r);
    end else begin
      opx3_nxt = rnd_a[CPT_K_FRAC +: W+1];
      opy3_nxt = rnd_b[CPT_K_FRAC +: W+1];
    end
  end

  // stage data registers
  always_ff @(posedge clk) begin
    if (en1) begin
      mode1_r <= mode;
      sum1_r  <= sum1_nxt;
      dif1_r  <= dif1_nxt;
      x1_1_r  <= x1;
      x2_1_r  <= x2;
      sn1_r   <= sn;
      cs1_r   <= cs;
    end
    if (en2) begin
      mode2_r <= mode1_r;
      pa2_r   <= pa2_nxt;
      pb2_r   <= pb2_nxt;
      x1_2_r  <= x1_1_r;
      x2_2_r  <= x2_1_r;
      sn2_r   <= sn1_r;
      cs2_r   <= cs1_r;
    end
    if (en3) begin
      mode3_r <= mode2_r;
      opx3_r  <= opx3_nxt;
      opy3_r  <= opy3_nxt;
      sn3_r   <= sn2_r;
      cs3_r   <= cs2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_mode  = mode3_r;
  assign op_x      = opx3_r;
  assign op_y      = opy3_r;
  assign out_sn    = sn3_r;
  assign out_cs    = cs3_r;

endmodule

// File: hdl/cpt_rotate.sv
// ----------------------------------------------------------------------------
// cpt_rotate: park rotation
// Two stages: four products with sine and cosine, then signed sums rounded
// back to the sample scale (d/q forward, alpha/beta inverse).
// ----------------------------------------------------------------------------
module cpt_rotate
  import cpt_pkg::*;
#(
  parameter int W = CPT_SAMPLE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic signed [W:0]   op_x,
  input  logic signed [W:0]   op_y,
  input  logic signed [W-1:0] sn,
  input  logic signed [W-1:0] cs,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_mode,
  output logic signed [W+1:0] res_a,
  output logic signed [W+1:0] res_b
);

  localparam int PR_W = 2 * W + 1;
  localparam int SM_W = 2 * W + 2;

  logic v4_r, v5_r;
  logic en4, en5;

  logic                   mode4_r, mode5_r;
  logic signed [PR_W-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [PR_W-1:0] m1_nxt, m2_nxt, m3_nxt, m4_nxt;
  logic signed [SM_W-1:0] e1, e2, rnd1, rnd2;
  logic signed [W+1:0]    ra5_r, rb5_r;

  // elastic stage enables
  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign in_ready = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 4: rotation products
  assign m1_nxt = PR_W'(op_x) * PR_W'(cs);
  assign m2_nxt = PR_W'(op_y) * PR_W'(sn);
  assign m3_nxt = PR_W'(op_y) * PR_W'(cs);
  assign m4_nxt = PR_W'(op_x) * PR_W'(sn);

  // stage 5: combine by direction, round half up
  always_comb begin
    if (mode4_r == CPT_MODE_INV) begin
      e1 = SM_W'(m1_r) - SM_W'(m2_r);
      e2 = SM_W'(m4_r) + SM_W'(m3_r);
    end else begin
      e1 = SM_W'(m1_r) + SM_W'(m2_r);
      e2 = SM_W'(m3_r) - SM_W'(m4_r);
    end
  end

  assign rnd1 = e1 + (SM_W'(1) <<< (W - 2));
  assign rnd2 = e2 + (SM_W'(1) <<< (W - 2));

  always_ff @(posedge clk) begin
    if (en4) begin
      mode4_r <= mode;
      m1_r    <= m1_nxt;
      m2_r    <= m2_nxt;
      m3_r    <= m3_nxt;
      m4_r    <= m4_nxt;
    end
    if (en5) begin
      mode5_r <= mode4_r;
      ra5_r   <= rnd1[W-1 +: W+2];
      rb5_r   <= rnd2[W-1 +: W+2];
    end
  end

  assign out_valid = v5_r;
  assign out_mode  = mode5_r;
  assign res_a     = ra5_r;
  assign res_b     = rb5_r;

endmodule

// File: hdl/cpt_phase.sv
// ----------------------------------------------------------------------------
// cpt_phase: phase projection and output saturation
// Stage 6 scales beta by sqrt(3)/2, stage 7 forms u, v, w (inverse) or
// passes d, q (forward), clamps to the sample range and holds the result.
// ----------------------------------------------------------------------------
module cpt_phase
  import cpt_pkg::*;
#(
  parameter int W = CPT_SAMPLE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic signed [W+1:0] res_a,
  input  logic signed [W+1:0] res_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_first,
  output logic signed [W-1:0] out_second,
  output logic signed [W-1:0] out_third,
  output logic                out_clipped
);

  localparam int PK_W = W + 2 + CPT_K_W;
  localparam int AC_W = PK_W + 1;
  localparam int RS_W = W + 3;
  localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic v6_r, v7_r;
  logic en6, en7;

  logic                   mode6_r, mode7_r;
  logic signed [W+1:0]    a6_r, b6_r;
  logic signed [PK_W-1:0] pk6_r, pk6_nxt;
  logic signed [AC_W-1:0] ah, half, u_sum, w_sum;
  logic signed [RS_W-1:0] r1, r2, r3;
  logic [W:0]             s1, s2, s3;
  logic signed [W-1:0]    o1_r, o2_r, o3_r;
  logic                   clip_r;

  // clamp to the sample range, msb of the result is the clip flag
  function automatic logic [W:0] sat_clip(input logic signed [RS_W-1:0] x);
    logic [3:0] top;
    logic [W:0] res;
    top = x[RS_W-1 -: 4];
    if (top == 4'b0000 || top == 4'b1111) begin
      res = {1'b0, x[W-1:0]};
    end else if (x[RS_W-1]) begin
      res = {1'b1, SAT_MIN};
    end else begin
      res = {1'b1, SAT_MAX};
    end
    return res;
  endfunction

  // elastic stage enables
  assign en7      = !v7_r || out_ready;
  assign en6      = !v6_r || en7;
  assign in_ready = en6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en6) v6_r <= in_valid;
      if (en7) v7_r <= v6_r;
    end
  end

  // stage 6: beta times sqrt(3)/2
  assign pk6_nxt = PK_W'(res_b) * PK_W'(CPT_K_HALF_SQRT3);

  // stage 7: projection onto the phase axes, alpha/2 is a shift
  assign half  = AC_W'(1) <<< (CPT_K_FRAC - 1);
  assign ah    = AC_W'(a6_r) <<< (CPT_K_FRAC - 1);
  assign u_sum = ah + AC_W'(pk6_r) + half;
  assign w_sum = ah - AC_W'(pk6_r) + half;

  always_comb begin
    if (mode6_r == CPT_MODE_INV) begin
      r1 = u_sum[CPT_K_FRAC +: RS_W];
      r2 = -RS_W'(a6_r);
      r3 = w_sum[CPT_K_FRAC +: RS_W];
    end else begin
      r1 = RS_W'(a6_r);
      r2 = RS_W'(b6_r);
      r3 = '0;
    end
  end

  assign s1 = sat_clip(r1);
  assign s2 = sat_clip(r2);
  assign s3 = sat_clip(r3);

  always_ff @(posedge clk) begin
    if (en6) begin
      mode6_r <= mode;
      a6_r    <= res_a;
      b6_r    <= res_b;
      pk6_r   <= pk6_nxt;
    end
    if (en7) begin
      mode7_r <= mode6_r;
      o1_r    <= s1[W-1:0];
      o2_r    <= s2[W-1:0];
      o3_r    <= s3[W-1:0];
      clip_r  <= s1[W] | s2[W] | s3[W];
    end
  end

  assign out_valid   = v7_r;
  assign out_first   = o1_r;
  assign out_second  = o2_r;
  assign out_third   = o3_r;
  assign out_clipped = clip_r;

  // forward results carry no third phase
  a_fwd_third_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && mode7_r == CPT_MODE_FWD) |-> (o3_r == '0))
    else $error("forward beat with nonzero third output");

  // a clip flag means at least one output sits on a rail
  a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && clip_r) |-> (o1_r == SAT_MAX || o1_r == SAT_MIN ||
                          o2_r == SAT_MAX || o2_r == SAT_MIN ||
                          o3_r == SAT_MAX || o3_r == SAT_MIN))
    else $error("clip flag set with no output at a rail");

  // inverse v is the negated alpha whenever it is not clipped
  a_inv_v_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (en7 && v6_r && mode6_r == CPT_MODE_INV && !s2[W])
      |=> (o2_r == -$past(a6_r[W-1:0])))
    else $error("inverse v output is not the negated alpha");

endmodule

// File: hdl/clarke_park_transform_unit.sv
// ----------------------------------------------------------------------------
// clarke_park_transform_unit: forward/inverse clarke-park transform
// Top level: projection front end, rotation and phase/saturation back end.
// ----------------------------------------------------------------------------
// Usage
//   Input beat: in_mode selects forward (phases u,v,w to d,q) or inverse
//   (d,q to phases u,v,w), with the rotor sine and cosine in signed
//   fixed point, one integer bit. in_third is ignored in inverse mode.
//   Output beat: three saturated samples and out_clipped, set when any of
//   them was clamped. out_third is zero for forward beats.
//   Both channels are valid/ready. A beat is taken on every clock in which
//   valid and ready are high.
//   One beat per cycle is sustained while out_ready is high. The depth is
//   set by the two multiply steps of each direction, each followed by its
//   own rounding stage.
//   Each stage moves when it is empty or its successor moves, so while the
//   receiver stalls the pipeline fills its bubbles and keeps taking input
//   until every stage holds a beat; then in_ready drops. Nothing is lost or
//   repeated across a stall.
//   Reset clears all stage valid bits; the stage data registers are not reset.
// ----------------------------------------------------------------------------
module clarke_park_transform_unit
  import cpt_pkg::*;
#(
  parameter int SAMPLE_WIDTH = CPT_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic signed [SAMPLE_WIDTH-1:0] in_first,
  input  logic signed [SAMPLE_WIDTH-1:0] in_second,
  input  logic signed [SAMPLE_WIDTH-1:0] in_third,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sine,
  input  logic signed [SAMPLE_WIDTH-1:0] in_cosine,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_first,
  output logic signed [SAMPLE_WIDTH-1:0] out_second,
  output logic signed [SAMPLE_WIDTH-1:0] out_third,
  output logic                          out_clipped
);

  localparam int W = SAMPLE_WIDTH;

  // front end to rotation
  logic                fr_valid, fr_ready, fr_mode;
  logic signed [W:0]   fr_op_x, fr_op_y;
  logic signed [W-1:0] fr_sn, fr_cs;

  // rotation to back end
  logic                rp_valid, rp_ready, rp_mode;
  logic signed [W+1:0] rp_a, rp_b;

  // projection front end
  cpt_clarke #(.W(W)) u_clarke (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (in_mode),
    .x1        (in_first),
    .x2        (in_second),
    .x3        (in_third),
    .sn        (in_sine),
    .cs        (in_cosine),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_mode  (fr_mode),
    .op_x      (fr_op_x),
    .op_y      (fr_op_y),
    .out_sn    (fr_sn),
    .out_cs    (fr_cs)
  );

  // park rotation
  cpt_rotate #(.W(W)) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .mode      (fr_mode),
    .op_x      (fr_op_x),
    .op_y      (fr_op_y),
    .sn        (fr_sn),
    .cs        (fr_cs),
    .out_valid (rp_valid),
    .out_ready (rp_ready),
    .out_mode  (rp_mode),
    .res_a     (rp_a),
    .res_b     (rp_b)
  );

  // phase projection, saturation and output register
  cpt_phase #(.W(W)) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rp_valid),
    .in_ready    (rp_ready),
    .mode        (rp_mode),
    .res_a       (rp_a),
    .res_b       (rp_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_first   (out_first),
    .out_second  (out_second),
    .out_third   (out_third),
    .out_clipped (out_clipped)
  );

  // input backpressure only when the whole pipeline is full and stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output side is moving");

  // nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat valid right after reset");

endmodule
